@@ src/ttrs_pkg.sv @@
// Shared types and constants for the tick timer reprogram scheduler.
// Used by the register block, divider, datapath, controller and top level.
// No dependencies.
package ttrs_pkg;

   // Item kinds carried on the request tuser bits.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_SCHED = 2'd1;
   localparam logic [1:0] KIND_IRQ   = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_HAVE_CYCLE_CLOCK = 2'd0;
   localparam logic [1:0] REG_SCHED_ENABLED    = 2'd1;
   localparam logic [1:0] REG_FAST_PERIOD      = 2'd2;
   localparam logic [1:0] REG_FAST_TO_FREQ     = 2'd3;

   // Timer control words and count limits.
   localparam logic [7:0]  MODE_ONESHOT = 8'h30;
   localparam logic [7:0]  MODE_SQUARE  = 8'h36;
   localparam logic [15:0] MIN_COUNT    = 16'd20;
   localparam logic [15:0] MAX_COUNT    = 16'hFFFF;
   localparam logic [2:0]  LOAD_DELAY   = 3'd3;
   localparam int unsigned CLK_FREQ     = 1193182;

   // Divider sizing: 64-bit dividend, 32-bit divisor.
   localparam int unsigned DIV_STEPS_W = 7;
   localparam logic [DIV_STEPS_W-1:0] CATCH_STEPS = 7'd63;
   localparam logic [DIV_STEPS_W-1:0] COUNT_STEPS = 7'd44;

   typedef struct packed {
      logic        have_cycle_clock;
      logic        sched_enabled;
      logic [31:0] fast_period;
      logic [19:0] fast_to_freq;
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CATCH_DIV,
      ST_CATCH_UPD,
      ST_RESCHED,
      ST_PICK,
      ST_LOAD,
      ST_COUNT_DIV,
      ST_COUNT_FIN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic set_start_deadline;
      logic set_tick;
      logic start_catch;
      logic update_deadline;
      logic eval_resched;
      logic enter_oneshot;
      logic enter_square;
      logic load_count;
      logic finish_count;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] kind;
      logic       sched_ok;
      logic       have_cycle_clock;
      logic       now_ge_deadline;
      logic       cycle_deadline_set;
      logic       oneshot_mode;
      logic       event_zero;
      logic       outside_window;
      logic       count_direct;
      logic       div_busy;
      logic       out_free;
   } status_type;

endpackage

@@ src/ttrs_csr.sv @@
// Configuration registers behind an APB-style port.
// Depends on ttrs_pkg for the register indexes and the csr_type struct.
module ttrs_csr
   import ttrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output csr_type     cfg
);

   csr_type cfg_ff;
   csr_type cfg_in;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register write decode on the word index.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_HAVE_CYCLE_CLOCK: cfg_in.have_cycle_clock = csr_pwdata[0];
            REG_SCHED_ENABLED:    cfg_in.sched_enabled    = csr_pwdata[0];
            REG_FAST_PERIOD:      cfg_in.fast_period      = csr_pwdata;
            REG_FAST_TO_FREQ:     cfg_in.fast_to_freq     = csr_pwdata[19:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.have_cycle_clock <= 1'b0;
         cfg_ff.sched_enabled    <= 1'b0;
         cfg_ff.fast_period      <= 32'd1;
         cfg_ff.fast_to_freq     <= 20'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back mux.
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_HAVE_CYCLE_CLOCK: csr_prdata = {31'd0, cfg_ff.have_cycle_clock};
         REG_SCHED_ENABLED:    csr_prdata = {31'd0, cfg_ff.sched_enabled};
         REG_FAST_PERIOD:      csr_prdata = cfg_ff.fast_period;
         REG_FAST_TO_FREQ:     csr_prdata = {12'd0, cfg_ff.fast_to_freq};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ src/ttrs_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// The dividend is preloaded left-aligned so that only the given number of steps run.
// Depends on ttrs_pkg for the step counter width.
module ttrs_div
   import ttrs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [63:0]            dividend,
   input  logic [31:0]            divisor,
   input  logic [DIV_STEPS_W-1:0] steps,
   output logic                   busy,
   output logic [63:0]            quotient,
   output logic [31:0]            remainder
);

   logic                   busy_ff, busy_in;
   logic [DIV_STEPS_W-1:0] cnt_ff, cnt_in;
   logic [63:0]            dvd_ff, dvd_in;
   logic [31:0]            rem_ff, rem_in;
   logic [31:0]            dsr_ff, dsr_in;
   logic [32:0]            trial;
   logic [32:0]            trial_sub;
   logic                   fits;

   // One shift-and-subtract step.
   always_comb begin
      trial     = {rem_ff, dvd_ff[63]};
      trial_sub = trial - {1'b0, dsr_ff};
      fits      = ~trial_sub[32];
   end

   // Control and payload next values.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         dvd_in  = dividend;
         rem_in  = 32'd0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != 1);
         dvd_in  = {dvd_ff[62:0], fits};
         rem_in  = fits ? trial_sub[31:0] : trial[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

@@ src/ttrs_dp.sv @@
// Datapath: item registers, deadlines, timer mode, result assembly and output register.
// Depends on ttrs_pkg and instantiates ttrs_div for both divisions.
module ttrs_dp
   import ttrs_pkg::*;
#(
   parameter int TICK_RATE_HZ = 100
) (
   input  logic         clock,
   input  logic         reset,
   input  csr_type      cfg,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic [1:0]   req_tuser,
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata
);

   localparam logic [15:0] SQUARE_COUNT = 16'(CLK_FREQ / TICK_RATE_HZ);

   // Item and result registers.
   logic [1:0]  kind_ff, kind_in;
   logic [62:0] now_ff, now_in;
   logic [62:0] event_ff, event_in;
   logic        tick_ff, tick_in;
   logic        write_mode_ff, write_mode_in;
   logic [7:0]  mode_word_ff, mode_word_in;
   logic        write_count_ff, write_count_in;
   logic [15:0] count_ff, count_in;

   // Scheduler state.
   logic [63:0] deadline_ff, deadline_in;
   logic [62:0] cycle_deadline_ff, cycle_deadline_in;
   logic        oneshot_ff, oneshot_in;

   // Reschedule work registers.
   logic        outside_ff, outside_in;
   logic [63:0] target_ff, target_in;
   logic [63:0] diff_ff, diff_in;
   logic        past_ff, past_in;
   logic        mode_change_ff, mode_change_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic [31:0] fp_eff;
   logic [19:0] ratio_eff;
   logic [63:0] now_ext;
   logic [63:0] event_ext;
   logic [63:0] catch_dist;
   logic [31:0] three_quarter;
   logic [33:0] fp_times3;
   logic [64:0] upper_edge;
   logic [64:0] lower_edge;
   logic [31:0] catch_step;
   logic [63:0] catch_deadline;
   logic [43:0] quot_lo;
   logic [43:0] extra;
   logic [43:0] q_less;
   logic [15:0] fin_count;
   logic        out_free;

   // Divider interface.
   logic                   div_start;
   logic [63:0]            div_dividend;
   logic [31:0]            div_divisor;
   logic [DIV_STEPS_W-1:0] div_steps;
   logic                   div_busy;
   logic [63:0]            div_quot;
   logic [31:0]            div_rem;

   // Zero period or ratio behaves as one.
   assign fp_eff    = (cfg.fast_period == 32'd0) ? 32'd1 : cfg.fast_period;
   assign ratio_eff = (cfg.fast_to_freq == 20'd0) ? 20'd1 : cfg.fast_to_freq;
   assign now_ext   = {1'b0, now_ff};
   assign event_ext = {1'b0, event_ff};

   // Catch-up distance and the new deadline from its remainder.
   assign catch_dist     = now_ext - deadline_ff;
   assign catch_step     = fp_eff - div_rem;
   assign catch_deadline = ((div_rem == 32'd0) && (now_ext != deadline_ff)) ?
                           now_ext : now_ext + {32'd0, catch_step};

   // Window around the deadline in which square wave mode stays usable.
   assign fp_times3     = {2'b00, fp_eff} + {1'b0, fp_eff, 1'b0};
   assign three_quarter = fp_times3[33:2];
   assign upper_edge    = {1'b0, now_ext} + {33'd0, fp_eff};
   assign lower_edge    = {1'b0, now_ext} + {33'd0, three_quarter};

   // Count from the quotient with the load delay taken off.
   assign quot_lo = div_quot[43:0];
   assign extra   = {41'd0, LOAD_DELAY} + {43'd0, mode_change_ff};
   assign q_less  = quot_lo - extra;
   always_comb begin
      if (quot_lo < ({28'd0, MIN_COUNT} + extra)) begin
         fin_count = MIN_COUNT;
      end else if (q_less > {28'd0, MAX_COUNT}) begin
         fin_count = MAX_COUNT;
      end else begin
         fin_count = q_less[15:0];
      end
   end

   // Divider operand select.
   always_comb begin
      div_start    = cmd.start_catch | (cmd.load_count & ~(past_ff | (|diff_ff[63:40])));
      div_dividend = {diff_ff[39:0], 24'd0};
      div_divisor  = {12'd0, ratio_eff};
      div_steps    = COUNT_STEPS;
      if (cmd.start_catch) begin
         div_dividend = {catch_dist[62:0], 1'b0};
         div_divisor  = fp_eff;
         div_steps    = CATCH_STEPS;
      end
   end

   ttrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign out_free = ~rsp_valid_ff | rsp_tready;

   // Next values for the item, result and work registers.
   always_comb begin
      kind_in        = kind_ff;
      now_in         = now_ff;
      event_in       = event_ff;
      tick_in        = tick_ff;
      write_mode_in  = write_mode_ff;
      mode_word_in   = mode_word_ff;
      write_count_in = write_count_ff;
      count_in       = count_ff;
      outside_in     = outside_ff;
      target_in      = target_ff;
      diff_in        = diff_ff;
      past_in        = past_ff;
      mode_change_in = mode_change_ff;
      rsp_data_in    = rsp_data_ff;

      if (cmd.load_item) begin
         kind_in        = req_tuser;
         now_in         = req_tdata[62:0];
         event_in       = req_tdata[125:63];
         tick_in        = 1'b0;
         write_mode_in  = 1'b0;
         mode_word_in   = 8'd0;
         write_count_in = 1'b0;
         count_in       = 16'd0;
         mode_change_in = 1'b0;
      end
      if (cmd.set_tick) begin
         tick_in = 1'b1;
      end
      if (cmd.eval_resched) begin
         outside_in = (upper_edge < {1'b0, deadline_ff}) ||
                      (lower_edge > {1'b0, deadline_ff});
         target_in  = (event_ext > deadline_ff) ? deadline_ff : event_ext;
      end
      if (cmd.enter_oneshot) begin
         diff_in = target_ff - now_ext;
         past_in = (target_ff <= now_ext);
         if (!oneshot_ff) begin
            write_mode_in  = 1'b1;
            mode_word_in   = MODE_ONESHOT;
            mode_change_in = 1'b1;
         end
      end
      if (cmd.enter_square) begin
         write_mode_in  = 1'b1;
         mode_word_in   = MODE_SQUARE;
         write_count_in = 1'b1;
         count_in       = SQUARE_COUNT;
      end
      if (cmd.load_count) begin
         write_count_in = 1'b1;
         count_in       = past_ff ? MIN_COUNT : MAX_COUNT;
      end
      if (cmd.finish_count) begin
         count_in = fin_count;
      end
      if (cmd.emit) begin
         rsp_data_in = {5'd0, count_ff, write_count_ff, mode_word_ff,
                        write_mode_ff, tick_ff};
      end
   end

   // Next values for the scheduler state and output valid.
   always_comb begin
      deadline_in       = deadline_ff;
      cycle_deadline_in = cycle_deadline_ff;
      oneshot_in        = oneshot_ff;
      rsp_valid_in      = rsp_valid_ff;

      if (cmd.set_start_deadline) begin
         deadline_in = now_ext;
      end
      if (cmd.update_deadline) begin
         deadline_in = catch_deadline;
      end
      if (cmd.eval_resched) begin
         cycle_deadline_in = event_ff;
      end
      if (cmd.enter_oneshot) begin
         oneshot_in = 1'b1;
      end
      if (cmd.enter_square) begin
         oneshot_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff       <= 64'd0;
         cycle_deadline_ff <= 63'd0;
         oneshot_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         deadline_ff       <= deadline_in;
         cycle_deadline_ff <= cycle_deadline_in;
         oneshot_ff        <= oneshot_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      now_ff         <= now_in;
      event_ff       <= event_in;
      tick_ff        <= tick_in;
      write_mode_ff  <= write_mode_in;
      mode_word_ff   <= mode_word_in;
      write_count_ff <= write_count_in;
      count_ff       <= count_in;
      outside_ff     <= outside_in;
      target_ff      <= target_in;
      diff_ff        <= diff_in;
      past_ff        <= past_in;
      mode_change_ff <= mode_change_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Status toward the controller.
   always_comb begin
      status.kind               = kind_ff;
      status.sched_ok           = cfg.sched_enabled & cfg.have_cycle_clock &
                                  (event_ff != cycle_deadline_ff);
      status.have_cycle_clock   = cfg.have_cycle_clock;
      status.now_ge_deadline    = (now_ext >= deadline_ff);
      status.cycle_deadline_set = (cycle_deadline_ff != 63'd0);
      status.oneshot_mode       = oneshot_ff;
      status.event_zero         = (event_ff == 63'd0);
      status.outside_window     = outside_ff;
      status.count_direct       = past_ff | (|diff_ff[63:40]);
      status.div_busy           = div_busy;
      status.out_free           = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/ttrs_ctrl.sv @@
// Controller state machine that sequences one item through the datapath.
// Depends on ttrs_pkg for the state, command and status types.
module ttrs_ctrl
   import ttrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.kind)
               KIND_START: state_in = ST_EMIT;
               KIND_SCHED: state_in = status.sched_ok ? ST_RESCHED : ST_EMIT;
               KIND_IRQ: begin
                  priority if (!status.have_cycle_clock) begin
                     state_in = ST_EMIT;
                  end else if (status.now_ge_deadline) begin
                     state_in = ST_CATCH_DIV;
                  end else if (status.cycle_deadline_set || status.oneshot_mode) begin
                     state_in = ST_RESCHED;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
               default: state_in = ST_EMIT;
            endcase
         end
         ST_CATCH_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_CATCH_UPD;
            end
         end
         ST_CATCH_UPD: begin
            if (status.cycle_deadline_set || status.oneshot_mode) begin
               state_in = ST_RESCHED;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_RESCHED: begin
            if (!status.oneshot_mode && status.event_zero) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (!status.event_zero || status.outside_window) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_LOAD: begin
            state_in = status.count_direct ? ST_EMIT : ST_COUNT_DIV;
         end
         ST_COUNT_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_COUNT_FIN;
            end
         end
         ST_COUNT_FIN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_DECODE: begin
            if (status.kind == KIND_START) begin
               cmd.set_start_deadline = 1'b1;
            end
            if (status.kind == KIND_IRQ) begin
               if (!status.have_cycle_clock) begin
                  cmd.set_tick = 1'b1;
               end else if (status.now_ge_deadline) begin
                  cmd.set_tick    = 1'b1;
                  cmd.start_catch = 1'b1;
               end
            end
         end
         ST_CATCH_DIV: cmd = '0;
         ST_CATCH_UPD: cmd.update_deadline = 1'b1;
         ST_RESCHED:   cmd.eval_resched = 1'b1;
         ST_PICK: begin
            if (!status.event_zero || status.outside_window) begin
               cmd.enter_oneshot = 1'b1;
            end else if (status.oneshot_mode) begin
               cmd.enter_square = 1'b1;
            end
         end
         ST_LOAD:      cmd.load_count = 1'b1;
         ST_COUNT_DIV: cmd = '0;
         ST_COUNT_FIN: cmd.finish_count = 1'b1;
         ST_EMIT:      cmd.emit = status.out_free;
         default:      cmd = '0;
      endcase
   end

endmodule

@@ src/tick_timer_reprogram_scheduler.sv @@
// Tick timer reprogram scheduler: decides how counter 0 of an interval timer is reloaded.
// The request channel carries one item per beat: tuser holds the kind (start, schedule
// request, timer interrupt), tdata holds now and the next cycle event time.
// The response channel returns exactly one beat per request: the tick flag, the mode
// word write and the counter reload value.
// Configuration registers sit behind the csr_ APB-style port; the user must write them
// only while idle; the block itself does not enforce this. One item is processed at a
// time. A start item or a plain tick passes from the accepted request beat through the
// decode state to the emit state, which loads the output register. An interrupt that
// catches up the tick deadline runs the shared restoring divider for 63 steps, and a
// one-shot count that is not set directly runs it for 44 steps, so an item needing both
// is the slowest.
// The next request is accepted as soon as the response sits in the output register,
// even while the receiver stalls; a finished item waits until that register drains.
// Synchronous reset clears deadlines, the timer mode (square wave) and the registers
// to their defaults, and empties the output register.
// Depends on ttrs_pkg, ttrs_csr, ttrs_dp (with ttrs_div) and ttrs_ctrl.
module tick_timer_reprogram_scheduler
   import ttrs_pkg::*;
#(
   parameter int TICK_RATE_HZ = 100
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [62:0] now, [125:63] next_cycle_event, rest zero
   input  logic [1:0]   req_tuser,   // [1:0] kind
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [0] tick, [1] write_mode, [9:2] mode_word,
                                     // [10] write_count, [26:11] count, rest zero
   // Configuration port.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   csr_type    cfg;
   cmd_type    cmd;
   status_type status;

   ttrs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ttrs_dp #(
      .TICK_RATE_HZ (TICK_RATE_HZ)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ttrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for tick_timer_reprogram_scheduler.
// Drives request beats and register writes, predicts every response beat, and checks it.
// Depends on ttrs_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module testbench;
   import ttrs_pkg::*;

   localparam int unsigned TICK_HZ    = 100;
   localparam int          TIMEOUT_NS = 5_000_000;
   localparam int          PHASE_BEATS = 125;
   localparam int          SETTLE_CYCLES = 150;
   localparam logic [1:0]  KIND_NONE = 2'd3;
   localparam logic [15:0] SQUARE_RELOAD = 16'(CLK_FREQ / TICK_HZ);
   localparam logic [62:0] ALL_ONES = '1;
   localparam logic [62:0] HALF_RANGE = 63'h4000000000000000;

   // One response beat, laid out as in rsp_tdata from bit 0 up.
   typedef struct packed {
      logic [15:0] count;
      logic        write_count;
      logic [7:0]  mode_word;
      logic        write_mode;
      logic        tick;
   } reload_type;

   // One row of the directed table: a register write or a request beat.
   typedef struct packed {
      logic        reg_op;
      logic [1:0]  reg_idx;
      logic [31:0] reg_val;
      logic [1:0]  kind;
      logic [62:0] now;
      logic [62:0] ev;
      logic        typed;
      reload_type  want;
   } step_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // [62:0] now, [125:63] next_cycle_event, rest zero
   logic [1:0]   req_tuser = '0;   // [1:0] kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;        // [0] tick, [1] write_mode, [9:2] mode_word,
                                   // [10] write_count, [26:11] count, rest zero
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Predictor state and register copies.
   logic [63:0]  tick_due;
   logic [63:0]  event_due;
   logic         oneshot_mode;
   logic         cfg_cycle_clock;
   logic         cfg_sched_en;
   logic [31:0]  cfg_period;
   logic [19:0]  cfg_ratio;

   reload_type   expected_reloads[$];
   step_type     directed_rows[$];
   reload_type   got_reload;
   reload_type   want_reload;
   int           fail_count = 0;
   int           send_idle = 0;
   int           rcv_idle = 0;

   tick_timer_reprogram_scheduler #(.TICK_RATE_HZ(TICK_HZ)) uut (.*);

   always #5 clock = ~clock;

   // Records one failure; only the first few are printed.
   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s", $realtime, what);
   endtask

   function automatic reload_type reload(input logic tick, input logic wm,
                                         input logic [7:0] mw, input logic wc,
                                         input logic [15:0] cnt);
      reload_type r;
      r.tick = tick;
      r.write_mode = wm;
      r.mode_word = mw;
      r.write_count = wc;
      r.count = cnt;
      return r;
   endfunction

   function automatic step_type row_item(input logic [1:0] kind, input logic [62:0] now,
                                         input logic [62:0] ev);
      step_type s;
      s = '0;
      s.kind = kind;
      s.now = now;
      s.ev = ev;
      return s;
   endfunction

   function automatic step_type row_check(input logic [1:0] kind, input logic [62:0] now,
                                          input logic [62:0] ev, input reload_type want);
      step_type s;
      s = row_item(kind, now, ev);
      s.typed = 1'b1;
      s.want = want;
      return s;
   endfunction

   function automatic step_type row_reg(input logic [1:0] idx, input logic [31:0] val);
      step_type s;
      s = '0;
      s.reg_op = 1'b1;
      s.reg_idx = idx;
      s.reg_val = val;
      return s;
   endfunction

   function automatic logic [62:0] rand63();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[62:0];
   endfunction

   // Decides the timer reprogramming for a new event time and updates the mode.
   function automatic void plan_reload(input logic [63:0] now, input logic [63:0] ev,
                                       inout reload_type r);
      logic [63:0] period, ratio, target, diff, quot, extra, cnt;
      period = (cfg_period == 0) ? 64'd1 : 64'(cfg_period);
      ratio = (cfg_ratio == 0) ? 64'd1 : 64'(cfg_ratio);
      event_due = ev;
      if (!oneshot_mode && ev == 0)
         return;
      if (ev != 0 || now + period < tick_due || now + ((3 * period) >> 2) > tick_due) begin
         target = (ev > tick_due) ? tick_due : ev;
         extra = 64'(LOAD_DELAY);
         // Switching to one-shot costs the mode write, so the count is one shorter.
         if (!oneshot_mode) begin
            oneshot_mode = 1'b1;
            r.write_mode = 1'b1;
            r.mode_word = MODE_ONESHOT;
            extra = extra + 1;
         end
         if (target <= now) begin
            cnt = 64'(MIN_COUNT);
         end else begin
            diff = target - now;
            if (diff >= (64'd1 << 40)) begin
               cnt = 64'(MAX_COUNT);
            end else begin
               quot = (diff * 16) / ratio;
               if (quot < 64'(MIN_COUNT) + extra)
                  cnt = 64'(MIN_COUNT);
               else if (quot - extra > 64'(MAX_COUNT))
                  cnt = 64'(MAX_COUNT);
               else
                  cnt = quot - extra;
            end
         end
         r.write_count = 1'b1;
         r.count = cnt[15:0];
      end else if (oneshot_mode) begin
         oneshot_mode = 1'b0;
         r.write_mode = 1'b1;
         r.mode_word = MODE_SQUARE;
         r.write_count = 1'b1;
         r.count = SQUARE_RELOAD;
      end
   endfunction

   // Works out the response beat for one accepted request and advances the state.
   function automatic reload_type compute_reload(input logic [1:0] kind,
                                                 input logic [62:0] now_in,
                                                 input logic [62:0] ev_in);
      reload_type r;
      logic [63:0] now, ev, period, steps;
      r = '0;
      now = {1'b0, now_in};
      ev = {1'b0, ev_in};
      case (kind)
         KIND_START: begin
            tick_due = now;
         end
         KIND_SCHED: begin
            if (cfg_sched_en && cfg_cycle_clock && ev != event_due)
               plan_reload(now, ev, r);
         end
         KIND_IRQ: begin
            if (!cfg_cycle_clock) begin
               r.tick = 1'b1;
            end else begin
               // Catch the deadline up to now or beyond in whole periods, at least one.
               if (now >= tick_due) begin
                  period = (cfg_period == 0) ? 64'd1 : 64'(cfg_period);
                  steps = (now - tick_due + period - 1) / period;
                  if (steps == 0)
                     steps = 1;
                  r.tick = 1'b1;
                  tick_due = tick_due + steps * period;
               end
               if (event_due != 0 || oneshot_mode)
                  plan_reload(now, ev, r);
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Event time for a random beat: none, unchanged, ahead, behind or anywhere.
   function automatic logic [62:0] pick_event(input logic [62:0] now, input logic [62:0] span);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 30)
         return '0;
      else if (sel < 40)
         return event_due[62:0];
      else if (sel < 80)
         return now + span;
      else if (sel < 90)
         return now - span;
      return rand63();
   endfunction

   // Random beat built around the current tick deadline so that catch-up, the
   // square wave window and the count limits are all reached.
   task automatic pick_random_item(output logic [1:0] kind, output logic [62:0] now,
                                   output logic [62:0] ev);
      logic [62:0] anchor, period, ratio, span;
      int unsigned sel;
      period = (cfg_period == 0) ? 63'd1 : 63'(cfg_period);
      ratio = (cfg_ratio == 0) ? 63'd1 : 63'(cfg_ratio);
      anchor = tick_due[63] ? rand63() : tick_due[62:0];
      span = (63'($urandom_range(0, 70000)) * ratio) >> 4;
      sel = $urandom_range(0, 99);
      kind = KIND_IRQ;
      now = anchor;
      ev = '0;
      if (sel < 6) begin
         kind = KIND_START;
         now = ($urandom_range(0, 3) == 0) ? rand63() : anchor + 63'($urandom_range(0, 5000));
         ev = rand63();
      end else if (sel < 60) begin
         case ($urandom_range(0, 3))
            0: now = anchor + period * 63'($urandom_range(0, 4)) - 63'($urandom_range(0, 1));
            1: now = anchor - period + 63'($urandom_range(0, period[31:0] >> 2));
            2: now = anchor - 63'($urandom_range(1, period[31:0]));
            default: now = anchor + (rand63() >> $urandom_range(20, 62));
         endcase
         ev = pick_event(now, span);
      end else if (sel < 88) begin
         kind = KIND_SCHED;
         now = anchor - 63'($urandom_range(0, period[31:0]));
         ev = pick_event(now, span);
      end else if (sel < 93) begin
         kind = KIND_NONE;
         now = rand63();
         ev = rand63();
      end else begin
         kind = 2'($urandom_range(0, 3));
         now = rand63();
         ev = rand63();
      end
   endtask

   // Sends one request beat; the expectation is queued when the beat is taken.
   task automatic send_item(input logic [1:0] kind, input logic [62:0] now,
                            input logic [62:0] ev, input logic typed, input reload_type want);
      reload_type predicted;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, ev, now};
      do @(posedge clock); while (!req_tready);
      predicted = compute_reload(kind, now, ev);
      expected_reloads.push_back(typed ? want : predicted);
   endtask

   // Stops sending and waits until every outstanding response has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_reloads.size() != 0)
         @(posedge clock);
   endtask

   // Writes a register, reads it back, and updates the predictor's copy.
   task automatic write_csr(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] stored;
      case (idx)
         REG_HAVE_CYCLE_CLOCK: stored = {31'd0, val[0]};
         REG_SCHED_ENABLED:    stored = {31'd0, val[0]};
         REG_FAST_PERIOD:      stored = val;
         default:              stored = {12'd0, val[19:0]};
      endcase
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_HAVE_CYCLE_CLOCK: cfg_cycle_clock = stored[0];
         REG_SCHED_ENABLED:    cfg_sched_en = stored[0];
         REG_FAST_PERIOD:      cfg_period = stored;
         default:              cfg_ratio = stored[19:0];
      endcase
      // Read the same register back.
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== stored)
         note_failure($sformatf("register %0d reads %h, expected %h", idx, csr_prdata, stored));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic hcc, input logic se, input logic [31:0] period,
                            input logic [31:0] ratio);
      write_csr(REG_HAVE_CYCLE_CLOCK, {31'd0, hcc});
      write_csr(REG_SCHED_ENABLED, {31'd0, se});
      write_csr(REG_FAST_PERIOD, period);
      write_csr(REG_FAST_TO_FREQ, ratio);
   endtask

   // Response side: random backpressure and a field-by-field check of each beat.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_reload = rsp_tdata[26:0];
         if (expected_reloads.size() == 0) begin
            note_failure($sformatf("response beat %h with nothing expected", rsp_tdata));
         end else begin
            want_reload = expected_reloads.pop_front();
            if (got_reload.tick !== want_reload.tick ||
                got_reload.write_mode !== want_reload.write_mode ||
                got_reload.mode_word !== want_reload.mode_word ||
                got_reload.write_count !== want_reload.write_count ||
                got_reload.count !== want_reload.count)
               note_failure($sformatf({"reload mismatch: expected tick=%0d wm=%0d mode=%h ",
                  "wc=%0d count=%0d, got tick=%0d wm=%0d mode=%h wc=%0d count=%0d"},
                  want_reload.tick, want_reload.write_mode, want_reload.mode_word,
                  want_reload.write_count, want_reload.count,
                  got_reload.tick, got_reload.write_mode, got_reload.mode_word,
                  got_reload.write_count, got_reload.count));
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle);
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL tick_timer_reprogram_scheduler");
      $finish;
   end

   initial begin
      logic [1:0]  kind;
      logic [62:0] now_v;
      logic [62:0] ev_v;

      tick_due = '0;
      event_due = '0;
      oneshot_mode = 1'b0;
      cfg_cycle_clock = 1'b0;
      cfg_sched_en = 1'b0;
      cfg_period = 32'd1;
      cfg_ratio = 20'd1;

      // Directed table. Typed rows carry the response read straight off the rules.
      directed_rows.push_back(row_check(KIND_IRQ, 63'd5, 63'd0, reload(1, 0, 0, 0, 0)));
      directed_rows.push_back(row_check(KIND_SCHED, 63'd0, 63'd100, '0));
      directed_rows.push_back(row_check(KIND_NONE, ALL_ONES, ALL_ONES, '0));
      directed_rows.push_back(row_check(KIND_START, 63'd1000, 63'd0, '0));
      directed_rows.push_back(row_reg(REG_HAVE_CYCLE_CLOCK, 32'd1));
      directed_rows.push_back(row_check(KIND_SCHED, 63'd0, 63'd50, '0));
      directed_rows.push_back(row_reg(REG_SCHED_ENABLED, 32'd1));
      directed_rows.push_back(row_reg(REG_FAST_PERIOD, 32'd1000));
      directed_rows.push_back(row_reg(REG_FAST_TO_FREQ, 32'd16));
      // Unchanged request, then a deadline already past, then the same request again.
      directed_rows.push_back(row_check(KIND_SCHED, 63'd0, 63'd0, '0));
      directed_rows.push_back(row_check(KIND_SCHED, 63'd500, 63'd400,
                                        reload(0, 1, MODE_ONESHOT, 1, MIN_COUNT)));
      directed_rows.push_back(row_check(KIND_SCHED, 63'd500, 63'd400, '0));
      directed_rows.push_back(row_item(KIND_SCHED, 63'd0, ALL_ONES));
      // Inside the window with no event: back to square wave.
      directed_rows.push_back(row_check(KIND_IRQ, 63'd100, 63'd0,
                                        reload(0, 1, MODE_SQUARE, 1, SQUARE_RELOAD)));
      // Catch-up over several periods, an exact hit, then an early interrupt.
      directed_rows.push_back(row_check(KIND_IRQ, 63'd5000, 63'd0, reload(1, 0, 0, 0, 0)));
      directed_rows.push_back(row_check(KIND_IRQ, 63'd5000, 63'd0, reload(1, 0, 0, 0, 0)));
      directed_rows.push_back(row_check(KIND_IRQ, 63'd5001, 63'd123, '0));
      // A far deadline saturates the count.
      directed_rows.push_back(row_check(KIND_START, HALF_RANGE, 63'd0, '0));
      directed_rows.push_back(row_check(KIND_SCHED, 63'd0, ALL_ONES,
                                        reload(0, 1, MODE_ONESHOT, 1, MAX_COUNT)));
      // Zero period and ratio behave as one.
      directed_rows.push_back(row_reg(REG_FAST_PERIOD, 32'd0));
      directed_rows.push_back(row_reg(REG_FAST_TO_FREQ, 32'd0));
      directed_rows.push_back(row_item(KIND_START, 63'd100, 63'd0));
      directed_rows.push_back(row_item(KIND_SCHED, 63'd10, 63'd50));
      directed_rows.push_back(row_item(KIND_IRQ, 63'd300, 63'd0));
      // Largest period and ratio.
      directed_rows.push_back(row_reg(REG_FAST_PERIOD, 32'hFFFF_FFFF));
      directed_rows.push_back(row_reg(REG_FAST_TO_FREQ, 32'hF_FFFF));
      directed_rows.push_back(row_item(KIND_START, 63'd0, 63'd0));
      directed_rows.push_back(row_item(KIND_SCHED, 63'd0, HALF_RANGE));
      directed_rows.push_back(row_item(KIND_IRQ, ALL_ONES, ALL_ONES));
      directed_rows.push_back(row_item(KIND_SCHED, 63'd0, 63'd0));
      directed_rows.push_back(row_reg(REG_HAVE_CYCLE_CLOCK, 32'd0));
      directed_rows.push_back(row_check(KIND_IRQ, 63'd7, 63'd0, reload(1, 0, 0, 0, 0)));
      directed_rows.push_back(row_check(KIND_NONE, 63'd0, 63'd0, '0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle = 21;
      rcv_idle = 65;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].reg_op) begin
            drain();
            write_csr(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         end else begin
            send_item(directed_rows[i].kind, directed_rows[i].now, directed_rows[i].ev,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle = 65;
            rcv_idle = 21;
         end else if (phase == 4) begin
            send_idle = 0;
            rcv_idle = 0;
         end
         drain();
         case (phase)
            0: configure(1'b1, 1'b1, 32'd1000, 32'd16);
            1: configure(1'b1, 1'b1, $urandom_range(1, 1 << 20), $urandom_range(1, 20'hF_FFFF));
            2: configure(1'b1, 1'b0, 32'd0, 32'd0);
            3: configure(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hF_FFFF);
            4: configure(1'b0, 1'b1, 32'd10, 32'd1);
            default: configure(1'b1, 1'b1, $urandom, $urandom_range(1, 20'hF_FFFF));
         endcase
         repeat (PHASE_BEATS) begin
            pick_random_item(kind, now_v, ev_v);
            send_item(kind, now_v, ev_v, 1'b0, '0);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS tick_timer_reprogram_scheduler");
      else
         $display("FAIL tick_timer_reprogram_scheduler");
      $finish;
   end

endmodule
